FILE: src/ffrp_pkg.sv
`default_nettype none

package ffrp_pkg;

  // fixed field widths
  localparam int unsigned EDGE_W = 9;
  localparam int unsigned STEP_W = 8;
  localparam int unsigned DIM_W  = 8;
  localparam int unsigned POS_W  = 8;

  // default atlas capacity and scan stride ceiling
  localparam int unsigned DEF_MAX_EDGE = 256;
  localparam int unsigned STEP_LIMIT   = 128;

  localparam logic [EDGE_W-1:0] ATLAS_EDGE_RESET = EDGE_W'(256);
  localparam logic [STEP_W-1:0] GRID_STEP_RESET  = STEP_W'(1);

  // configuration register indexes
  localparam logic CFG_ATLAS_EDGE = 1'b0;
  localparam logic CFG_GRID_STEP  = 1'b1;

  // request codes
  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_PLACE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_YCHK,
    ST_XCHK,
    ST_PROBE,
    ST_TEST,
    ST_SRD,
    ST_SWR,
    ST_RESULT
  } ffrp_state_t;

endpackage

`default_nettype wire

FILE: src/ffrp_occ_mem.sv
`default_nettype none

module ffrp_occ_mem #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/first_fit_rect_placer_unit.sv
// first-fit rectangle placer on a square occupancy bitmap
//
// in channel (in_valid / in_stall) takes one request per transfer: req_type
// selects clear (no result) or place (one result on the out channel).
// out channel (out_valid / out_stall) carries placed, pos_x, pos_y; a failed
// place returns placed = 0 with both positions zero.
// config port: cfg_we writes cfg_data into register cfg_index (0 atlas_edge,
// 1 grid_step); write only while the block is idle.
// the bitmap lives in a one-port-read, one-port-write ram of 2**clog2(MAX_EDGE)
// bit words; each sampled cell costs a read and a test, a claimed cell a
// read-modify-write.
// a place, from transfer to out_valid, runs setup, then row checks, column
//   checks, a probe and a test per cell probed and a read and a write per
//   cell claimed, the last failing check of each loop included; the probe loop
//   dominates, so a place slows with occupancy; idle comes before the next transfer
// a clear request, and reset, sweep all ram words, one word a cycle;
// no request is taken meanwhile.
// a finished result sits in the output register while the next request is
// accepted; a new result waits in place while the receiver stalls.
`default_nettype none

module first_fit_rect_placer_unit
  import ffrp_pkg::*;
#(
  parameter int unsigned MAX_EDGE = DEF_MAX_EDGE
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              req_type,
  input  wire logic [DIM_W-1:0]  rect_width,
  input  wire logic [DIM_W-1:0]  rect_height,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   placed,
  output logic [POS_W-1:0]       pos_x,
  output logic [POS_W-1:0]       pos_y,
  // config write port
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [EDGE_W-1:0] cfg_data
);

  // ram geometry: word width is the power of two at or above MAX_EDGE
  localparam int unsigned BW    = $clog2(MAX_EDGE);
  localparam int unsigned WW    = 1 << BW;
  localparam int unsigned CELLS = MAX_EDGE * MAX_EDGE;
  localparam int unsigned DEPTH = (CELLS + WW - 1) / WW;
  localparam int unsigned AW    = $clog2(DEPTH);
  // flat cell index width
  localparam int unsigned IW    = $clog2(CELLS);
  // coordinate width, roomy enough for position + step + padded size
  localparam int unsigned CW    = (($clog2(MAX_EDGE + 1) > 9) ? $clog2(MAX_EDGE + 1) : 9) + 1;
  localparam int unsigned PW    = CW + STEP_W;
  // padded size and in-rectangle offsets
  localparam int unsigned SW    = DIM_W + 1;

  ffrp_state_t state, state_next;

  // config registers
  logic [EDGE_W-1:0] atlas_edge;
  logic [STEP_W-1:0] grid_step;

  // per-request working registers
  logic [CW-1:0]     edge_r;
  logic [STEP_W-1:0] step_r;
  logic [SW-1:0]     w_r, h_r;
  logic [IW-1:0]     stepedge;
  logic [CW-1:0]     cx, cy;
  logic [IW-1:0]     ybase, rowb;
  logic [SW-1:0]     ci, cj;
  logic [AW-1:0]     paddr;
  logic [BW-1:0]     psel;
  logic [AW-1:0]     ptr;
  logic              res_placed;

  // ram ports
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WW-1:0]     mem_rdata;

  logic              accept;
  logic              slot_free;
  logic              res_load;
  logic [CW-1:0]     eff_edge;
  logic [STEP_W-1:0] eff_step;
  logic [PW-1:0]     prod;
  logic [IW-1:0]     idx;
  logic [SW:0]       i_adv, j_adv;
  logic              i_more, j_more, last_cell;
  logic              yfit, xfit;
  logic              cell_set;
  logic              clear_done;

  assign accept    = in_valid & ~in_stall;
  assign slot_free = ~out_valid | ~out_stall;
  assign res_load  = (state == ST_RESULT) & slot_free;

  // saturate the registers to what the scan supports
  always_comb begin
    if (CW'(atlas_edge) > CW'(MAX_EDGE)) begin
      eff_edge = CW'(MAX_EDGE);
    end else begin
      eff_edge = CW'(atlas_edge);
    end
    if (grid_step == '0) begin
      eff_step = STEP_W'(1);
    end else if (grid_step > STEP_W'(STEP_LIMIT)) begin
      eff_step = STEP_W'(STEP_LIMIT);
    end else begin
      eff_step = grid_step;
    end
  end

  // row stride of one grid step, worked out once per request
  assign prod = PW'(step_r) * PW'(edge_r);

  // candidate fits inside the atlas (strictly below the edge)
  assign yfit = (cy + CW'(h_r)) < edge_r;
  assign xfit = (cx + CW'(w_r)) < edge_r;

  // sampled cell address
  assign idx = rowb + IW'(cx) + IW'(ci);

  // walk over sampled cells of the padded rectangle
  assign i_adv     = (SW + 1)'(ci) + (SW + 1)'(step_r);
  assign j_adv     = (SW + 1)'(cj) + (SW + 1)'(step_r);
  assign i_more    = i_adv < (SW + 1)'(w_r);
  assign j_more    = j_adv < (SW + 1)'(h_r);
  assign last_cell = ~i_more & ~j_more;

  assign cell_set   = mem_rdata[psel];
  assign clear_done = (ptr == AW'(DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_SETUP;
        end
      end
      ST_SETUP:  state_next = ST_YCHK;
      ST_YCHK:   state_next = yfit ? ST_XCHK : ST_RESULT;
      ST_XCHK:   state_next = xfit ? ST_PROBE : ST_YCHK;
      ST_PROBE:  state_next = ST_TEST;
      ST_TEST: begin
        if (cell_set) begin
          state_next = ST_XCHK;
        end else if (last_cell) begin
          state_next = ST_SRD;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_SRD:    state_next = ST_SWR;
      ST_SWR:    state_next = last_cell ? ST_RESULT : ST_SRD;
      ST_RESULT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // state-decoded outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = paddr;
    mem_wdata = mem_rdata | (WW'(1) << psel);
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = '0;
      end
      ST_SWR:   mem_we = 1'b1;
      default:  ;
    endcase
  end

  assign mem_raddr = idx[BW+AW-1:BW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_edge <= ATLAS_EDGE_RESET;
      grid_step  <= GRID_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_EDGE: atlas_edge <= cfg_data;
        CFG_GRID_STEP:  grid_step  <= cfg_data[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  // clear sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (state == ST_CLEAR) begin
      ptr <= clear_done ? '0 : ptr + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_load | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      placed <= res_placed;
      pos_x  <= res_placed ? cx[POS_W-1:0] : '0;
      pos_y  <= res_placed ? cy[POS_W-1:0] : '0;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          edge_r <= eff_edge;
          step_r <= eff_step;
          w_r    <= SW'(rect_width) + SW'(1);
          h_r    <= SW'(rect_height) + SW'(1);
        end
      end
      ST_SETUP: begin
        stepedge <= IW'(prod);
        cy       <= CW'(1);
        ybase    <= IW'(edge_r);
      end
      ST_YCHK: begin
        cx <= CW'(1);
        if (!yfit) res_placed <= 1'b0;
      end
      ST_XCHK: begin
        if (xfit) begin
          ci   <= '0;
          cj   <= '0;
          rowb <= ybase;
        end else begin
          // row of candidates exhausted, next candidate row
          cy    <= cy + CW'(step_r);
          ybase <= ybase + stepedge;
        end
      end
      ST_PROBE, ST_SRD: begin
        paddr <= idx[BW+AW-1:BW];
        psel  <= idx[BW-1:0];
      end
      ST_TEST: begin
        if (cell_set) begin
          cx <= cx + CW'(step_r);
        end else if (last_cell) begin
          // candidate free: rewalk the same cells to claim them
          ci   <= '0;
          cj   <= '0;
          rowb <= ybase;
        end else if (i_more) begin
          ci <= i_adv[SW-1:0];
        end else begin
          ci   <= '0;
          cj   <= j_adv[SW-1:0];
          rowb <= rowb + stepedge;
        end
      end
      ST_SWR: begin
        if (last_cell) begin
          res_placed <= 1'b1;
        end else if (i_more) begin
          ci <= i_adv[SW-1:0];
        end else begin
          ci   <= '0;
          cj   <= j_adv[SW-1:0];
          rowb <= rowb + stepedge;
        end
      end
      default: ;
    endcase
  end

  ffrp_occ_mem #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_occ_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
